FILE: rtl/scoped_symbol_table_defines.svh
// Assertion macros used by the symbol table RTL.
`ifndef SCOPED_SYMBOL_TABLE_DEFINES_SVH
`define SCOPED_SYMBOL_TABLE_DEFINES_SVH
// Same-cycle implication, checked on the rising clock outside reset.
`define SST_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("symbol table assertion failed");
// Next-cycle implication, checked on the rising clock outside reset.
`define SST_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("symbol table assertion failed");
`endif

FILE: rtl/sst_pkg.sv
// Shared types, codes and helpers of the scoped symbol table.
`timescale 1ns / 1ps
package sst_pkg;
   localparam int TABLE_DEPTH_DEF = 128;
   localparam int LEVEL_DEPTH_DEF = 8;
   localparam int KEY_BITS_DEF    = 64;

   localparam int PCOUNT_MAX = 127;
   localparam int ADDR_MAX   = 32767;
   localparam int ADDR_MIN   = -32768;

   typedef enum logic [3:0] {
      ACT_OPEN   = 4'd0,
      ACT_CLOSE  = 4'd1,
      ACT_FUNC   = 4'd2,
      ACT_PARAM  = 4'd3,
      ACT_VAR    = 4'd4,
      ACT_CONST  = 4'd5,
      ACT_ENDP   = 4'd6,
      ACT_CHANGE = 4'd7,
      ACT_SEARCH = 4'd8,
      ACT_READ   = 4'd9
   } action_type;

   typedef enum logic [1:0] {
      KIND_VAR   = 2'd0,
      KIND_FUNC  = 2'd1,
      KIND_PARAM = 2'd2,
      KIND_CONST = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WORK,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [2:0]         level;
      logic signed [15:0] addr;
      logic signed [31:0] value;
      logic [6:0]         pcnt;
   } entry_type;

   function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
      logic signed [15:0] r;
      if (v > 32'(ADDR_MAX)) begin
         r = 16'(ADDR_MAX);
      end else if (v < 32'(ADDR_MIN)) begin
         r = 16'(ADDR_MIN);
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction
endpackage

FILE: rtl/sst_cell.sv
// One table slot of the rotating entry ring.
`timescale 1ns / 1ps
module sst_cell #(
   parameter int KEY_BITS = sst_pkg::KEY_BITS_DEF
) (
   input  logic                clock,
   input  logic [KEY_BITS-1:0] key_in,
   input  sst_pkg::entry_type  ent_in,
   output logic [KEY_BITS-1:0] key_q,
   output sst_pkg::entry_type  ent_q
);
   logic [KEY_BITS-1:0] key_ff;
   sst_pkg::entry_type  ent_ff;

   // advance the neighbor's word every cycle
   always_ff @(posedge clock) begin
      key_ff <= key_in;
      ent_ff <= ent_in;
   end

   assign key_q = key_ff;
   assign ent_q = ent_ff;
endmodule

FILE: rtl/scoped_symbol_table.sv
// Top level of the scoped symbol table: control, scope stack and cell ring.
// Each command keeps busy high while the ring makes a write turn and a read
// turn, and its result is flagged by rsp_strobe, high for a single cycle;
// start is taken again in that cycle. The entries sit
// in a ring of cells that rotates one slot per cycle: the first full turn
// applies the writes and runs the top-down search at the head cell, the
// second turn reads back the reported entry and the owning function's count.
// Results cannot be held off; take each one in its strobe cycle.
`timescale 1ns / 1ps
`include "scoped_symbol_table_defines.svh"
module scoped_symbol_table #(
   parameter int TABLE_DEPTH = sst_pkg::TABLE_DEPTH_DEF,
   parameter int LEVEL_DEPTH = sst_pkg::LEVEL_DEPTH_DEF,
   parameter int KEY_BITS    = sst_pkg::KEY_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [3:0]         req_action,
   input  logic [63:0]        req_name_key,
   input  logic signed [31:0] req_operand_value,
   input  logic [6:0]         req_target_index,
   output logic               rsp_strobe,
   output logic [6:0]         rsp_entry_index,
   output logic [1:0]         rsp_entry_kind,
   output logic [2:0]         rsp_entry_level,
   output logic signed [15:0] rsp_entry_address,
   output logic signed [31:0] rsp_entry_value,
   output logic signed [3:0]  rsp_current_level,
   output logic signed [15:0] rsp_next_local_address,
   output logic [6:0]         rsp_param_count,
   output logic               rsp_overflow
);
   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int LW = $clog2(LEVEL_DEPTH);
   localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);
   localparam logic signed [LW:0] LVL_TOP = (LW+1)'(LEVEL_DEPTH - 1);

   sst_pkg::state_type state_ff, state_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic [IW-1:0] head_ff, head_in;

   logic [3:0]          act_ff, act_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic signed [15:0]  saddr_ff, saddr_in;
   logic [IW-1:0]       tgt_ff, tgt_in;
   logic                tgt_ok_ff, tgt_ok_in;
   logic                wen_ff, wen_in;
   logic [IW-1:0]       widx_ff, widx_in;
   sst_pkg::entry_type  went_ff, went_in;
   logic                pinc_ff, pinc_in;
   logic [IW-1:0]       ofi_ff, ofi_in;
   logic [6:0]          shadow_ff, shadow_in;

   logic [IW-1:0]        top_ff, top_in;
   logic signed [LW:0]   lvl_ff, lvl_in;
   logic signed [15:0]   local_ff, local_in;
   logic [IW-1:0]        stop_ff [LEVEL_DEPTH];
   logic [IW-1:0]        stop_in [LEVEL_DEPTH];
   logic signed [15:0]   sloc_ff [LEVEL_DEPTH];
   logic signed [15:0]   sloc_in [LEVEL_DEPTH];

   logic [IW-1:0]      best_ff, best_in;
   logic [IW-1:0]      ridx_ff, ridx_in;
   logic               ovf_ff, ovf_in;
   sst_pkg::entry_type out_ent_ff, out_ent_in;
   logic [6:0]         out_pc_ff, out_pc_in;
   logic               rsp_strobe_ff, rsp_strobe_in;

   logic [KEY_BITS-1:0] ring_key [TABLE_DEPTH];
   sst_pkg::entry_type  ring_ent [TABLE_DEPTH];
   logic [KEY_BITS-1:0] upd_key;
   sst_pkg::entry_type  upd_ent;

   logic signed [LW:0] lvl_m1;
   logic [LW-1:0]      lvl_m1_idx;
   logic [IW:0]        fix_diff;
   logic [6:0]         shadow_base;

   assign lvl_m1     = lvl_ff - (LW+1)'(1);
   assign lvl_m1_idx = lvl_m1[LW-1:0];
   assign fix_diff   = {1'b0, head_ff} - {1'b0, ofi_ff};

   // ring of cells: slot k holds entry head-k, slot 0 is the head
   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_ring
      if (k == TABLE_DEPTH - 1) begin : g_tail
         sst_cell #(.KEY_BITS(KEY_BITS)) u_cell (
            .clock  (clock),
            .key_in (upd_key),
            .ent_in (upd_ent),
            .key_q  (ring_key[k]),
            .ent_q  (ring_ent[k])
         );
      end else begin : g_mid
         sst_cell #(.KEY_BITS(KEY_BITS)) u_cell (
            .clock  (clock),
            .key_in (ring_key[k+1]),
            .ent_in (ring_ent[k+1]),
            .key_q  (ring_key[k]),
            .ent_q  (ring_ent[k])
         );
      end
   end

   assign head_in = (head_ff == '0) ? LAST_IDX : head_ff - IW'(1);

   // write port at the head cell, active on the first turn only
   always_comb begin
      upd_key = ring_key[0];
      upd_ent = ring_ent[0];
      if (state_ff == sst_pkg::ST_WORK) begin
         if (wen_ff && head_ff == widx_ff) begin
            upd_key = key_ff;
            upd_ent = went_ff;
         end
         if (pinc_ff && head_ff == ofi_ff) begin
            upd_ent.pcnt = shadow_ff;
         end
         if (act_ff == sst_pkg::ACT_ENDP && head_ff > ofi_ff &&
             fix_diff <= (IW+1)'(shadow_ff)) begin
            upd_ent.addr = 16'(int'(fix_diff) - 1 - int'(shadow_ff));
         end
         if (act_ff == sst_pkg::ACT_CHANGE && tgt_ok_ff && head_ff == tgt_ff) begin
            upd_ent.addr = saddr_ff;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      act_in        = act_ff;
      key_in        = key_ff;
      saddr_in      = saddr_ff;
      tgt_in        = tgt_ff;
      tgt_ok_in     = tgt_ok_ff;
      wen_in        = wen_ff;
      widx_in       = widx_ff;
      went_in       = went_ff;
      pinc_in       = pinc_ff;
      ofi_in        = ofi_ff;
      shadow_in     = shadow_ff;
      top_in        = top_ff;
      lvl_in        = lvl_ff;
      local_in      = local_ff;
      stop_in       = stop_ff;
      sloc_in       = sloc_ff;
      best_in       = best_ff;
      ridx_in       = ridx_ff;
      ovf_in        = ovf_ff;
      out_ent_in    = out_ent_ff;
      out_pc_in     = out_pc_ff;
      rsp_strobe_in = 1'b0;
      shadow_base   = shadow_ff;

      case (state_ff)
         sst_pkg::ST_IDLE: begin
            if (start) begin
               act_in    = req_action;
               key_in    = req_name_key[KEY_BITS-1:0];
               saddr_in  = sst_pkg::sat16(req_operand_value);
               tgt_in    = IW'(req_target_index);
               tgt_ok_in = int'(req_target_index) < TABLE_DEPTH;
               wen_in    = 1'b0;
               pinc_in   = 1'b0;
               ovf_in    = 1'b0;
               ridx_in   = '0;
               best_in   = '0;
               state_in  = sst_pkg::ST_WORK;
               cnt_in    = '0;
               if (req_action inside {[sst_pkg::ACT_FUNC:sst_pkg::ACT_CONST]}) begin
                  if (top_ff == LAST_IDX) begin
                     ovf_in = 1'b1;
                  end else begin
                     wen_in        = 1'b1;
                     widx_in       = top_ff + IW'(1);
                     top_in        = top_ff + IW'(1);
                     ridx_in       = top_ff + IW'(1);
                     went_in       = '0;
                     went_in.level = 3'(lvl_ff);
                     // a fresh entry over the open function clears its count
                     shadow_base   = (top_ff + IW'(1) == ofi_ff) ? 7'd0 : shadow_ff;
                     shadow_in     = shadow_base;
                     case (req_action)
                        sst_pkg::ACT_FUNC: begin
                           went_in.kind = sst_pkg::KIND_FUNC;
                           went_in.addr = sst_pkg::sat16(req_operand_value);
                           ofi_in       = top_ff + IW'(1);
                           shadow_in    = 7'd0;
                        end
                        sst_pkg::ACT_PARAM: begin
                           went_in.kind = sst_pkg::KIND_PARAM;
                           pinc_in      = 1'b1;
                           if (shadow_base < 7'(sst_pkg::PCOUNT_MAX)) begin
                              shadow_in = shadow_base + 7'd1;
                           end
                        end
                        sst_pkg::ACT_VAR: begin
                           went_in.kind = sst_pkg::KIND_VAR;
                           went_in.addr = local_ff;
                           if (local_ff < 16'(sst_pkg::ADDR_MAX)) begin
                              local_in = local_ff + 16'sd1;
                           end
                        end
                        default: begin
                           went_in.kind  = sst_pkg::KIND_CONST;
                           went_in.value = req_operand_value;
                        end
                     endcase
                  end
               end else begin
                  case (req_action)
                     sst_pkg::ACT_OPEN: begin
                        if (lvl_ff >= LVL_TOP) begin
                           ovf_in = 1'b1;
                        end else if (lvl_ff < 0) begin
                           top_in   = '0;
                           local_in = sst_pkg::sat16(req_operand_value);
                           lvl_in   = '0;
                        end else begin
                           stop_in[lvl_ff[LW-1:0]] = top_ff;
                           sloc_in[lvl_ff[LW-1:0]] = local_ff;
                           local_in = sst_pkg::sat16(req_operand_value);
                           lvl_in   = lvl_ff + (LW+1)'(1);
                        end
                     end
                     sst_pkg::ACT_CLOSE: begin
                        if (lvl_ff > 0) begin
                           lvl_in   = lvl_m1;
                           top_in   = stop_ff[lvl_m1_idx];
                           local_in = sloc_ff[lvl_m1_idx];
                        end else if (lvl_ff == 0) begin
                           lvl_in = '1;
                        end
                     end
                     sst_pkg::ACT_ENDP: begin
                        ridx_in = ofi_ff;
                     end
                     sst_pkg::ACT_CHANGE, sst_pkg::ACT_READ: begin
                        if (int'(req_target_index) < TABLE_DEPTH) begin
                           ridx_in = IW'(req_target_index);
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         sst_pkg::ST_WORK: begin
            // keep the highest matching slot at or below the top
            if (act_ff == sst_pkg::ACT_SEARCH && head_ff != '0 && head_ff <= top_ff &&
                ring_key[0] == key_ff && head_ff > best_ff) begin
               best_in = head_ff;
            end
            cnt_in = cnt_ff + IW'(1);
            if (cnt_ff == LAST_IDX) begin
               state_in   = sst_pkg::ST_REPORT;
               cnt_in     = '0;
               out_ent_in = '0;
               out_pc_in  = '0;
               if (act_ff == sst_pkg::ACT_SEARCH) begin
                  ridx_in = best_in;
               end
            end
         end
         sst_pkg::ST_REPORT: begin
            if (ridx_ff != '0 && head_ff == ridx_ff) begin
               out_ent_in = ring_ent[0];
            end
            if (lvl_ff > 0 && head_ff == stop_ff[lvl_m1_idx]) begin
               out_pc_in = ring_ent[0].pcnt;
            end
            cnt_in = cnt_ff + IW'(1);
            if (cnt_ff == LAST_IDX) begin
               state_in      = sst_pkg::ST_IDLE;
               cnt_in        = '0;
               rsp_strobe_in = 1'b1;
            end
         end
         default: begin
            state_in = sst_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sst_pkg::ST_IDLE;
         cnt_ff        <= '0;
         head_ff       <= '0;
         top_ff        <= '0;
         lvl_ff        <= '1;
         local_ff      <= '0;
         ofi_ff        <= '0;
         shadow_ff     <= '0;
         wen_ff        <= 1'b0;
         pinc_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         head_ff       <= head_in;
         top_ff        <= top_in;
         lvl_ff        <= lvl_in;
         local_ff      <= local_in;
         ofi_ff        <= ofi_in;
         shadow_ff     <= shadow_in;
         wen_ff        <= wen_in;
         pinc_ff       <= pinc_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff     <= act_in;
      key_ff     <= key_in;
      saddr_ff   <= saddr_in;
      tgt_ff     <= tgt_in;
      tgt_ok_ff  <= tgt_ok_in;
      widx_ff    <= widx_in;
      went_ff    <= went_in;
      stop_ff    <= stop_in;
      sloc_ff    <= sloc_in;
      best_ff    <= best_in;
      ridx_ff    <= ridx_in;
      ovf_ff     <= ovf_in;
      out_ent_ff <= out_ent_in;
      out_pc_ff  <= out_pc_in;
   end

   assign busy                   = state_ff != sst_pkg::ST_IDLE;
   assign rsp_strobe             = rsp_strobe_ff;
   assign rsp_entry_index        = 7'(ridx_ff);
   assign rsp_entry_kind         = out_ent_ff.kind;
   assign rsp_entry_level        = out_ent_ff.level;
   assign rsp_entry_address      = out_ent_ff.addr;
   assign rsp_entry_value        = out_ent_ff.value;
   assign rsp_current_level      = 4'(lvl_ff);
   assign rsp_next_local_address = local_ff;
   assign rsp_param_count        = out_pc_ff;
   assign rsp_overflow           = ovf_ff;

   `SST_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   `SST_ASSERT_NEXT(a_report_strobe, state_ff == sst_pkg::ST_REPORT && cnt_ff == LAST_IDX, rsp_strobe_ff)
   `SST_ASSERT_SAME(a_strobe_idle, rsp_strobe_ff, state_ff == sst_pkg::ST_IDLE)
   `SST_ASSERT_SAME(a_miss_zero, rsp_strobe_ff && ridx_ff == '0, out_ent_ff == '0)
endmodule

FILE: tb/tb_scoped_symbol_table.sv
// Self-checking testbench for the scoped symbol table: scope, entry and search commands.
`timescale 1ns / 1ps
module tb_scoped_symbol_table;
   localparam int DEPTH = 128;
   localparam int LEVELS = 8;
   localparam int N_RANDOM = 1800;

   typedef struct {
      logic [3:0]         action;
      logic [63:0]        key;
      logic signed [31:0] opv;
      logic [6:0]         target;
   } cmd_type;

   typedef struct {
      logic [6:0]         index;
      logic [1:0]         kind;
      logic [2:0]         level;
      logic signed [15:0] address;
      logic signed [31:0] value;
      logic signed [3:0]  cur_level;
      logic signed [15:0] next_addr;
      logic [6:0]         pcount;
      logic               ovf;
   } lookup_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [3:0] req_action = '0;
   logic [63:0] req_name_key = '0;
   logic signed [31:0] req_operand_value = '0;
   logic [6:0] req_target_index = '0;
   logic rsp_strobe;
   logic [6:0] rsp_entry_index;
   logic [1:0] rsp_entry_kind;
   logic [2:0] rsp_entry_level;
   logic signed [15:0] rsp_entry_address;
   logic signed [31:0] rsp_entry_value;
   logic signed [3:0] rsp_current_level;
   logic signed [15:0] rsp_next_local_address;
   logic [6:0] rsp_param_count;
   logic rsp_overflow;

   scoped_symbol_table dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_name_key(req_name_key),
      .req_operand_value(req_operand_value), .req_target_index(req_target_index),
      .rsp_strobe(rsp_strobe), .rsp_entry_index(rsp_entry_index),
      .rsp_entry_kind(rsp_entry_kind), .rsp_entry_level(rsp_entry_level),
      .rsp_entry_address(rsp_entry_address), .rsp_entry_value(rsp_entry_value),
      .rsp_current_level(rsp_current_level),
      .rsp_next_local_address(rsp_next_local_address),
      .rsp_param_count(rsp_param_count), .rsp_overflow(rsp_overflow)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // shadow symbol table
   logic [63:0] sym_key[DEPTH];
   logic [1:0]  sym_kind[DEPTH];
   logic [2:0]  sym_level[DEPTH];
   int          sym_addr[DEPTH];
   int          sym_value[DEPTH];
   int          sym_pcount[DEPTH];
   int          top_idx = 0;
   int          nest = -1;
   int          local_addr = 0;
   int          saved_top[LEVELS];
   int          saved_addr[LEVELS];
   int          func_idx = 0;
   int          high_water = 0;

   cmd_type    pending_cmds[$];
   lookup_type pending_lookups[$];
   lookup_type expected_words[$];
   logic [63:0] key_pool[16];
   bit failed = 0;
   bit stim_done = 0;

   function automatic int clip16(longint v);
      if (v > sst_pkg::ADDR_MAX) return sst_pkg::ADDR_MAX;
      if (v < sst_pkg::ADDR_MIN) return sst_pkg::ADDR_MIN;
      return int'(v);
   endfunction

   function automatic int claim_entry(logic [63:0] k, logic [1:0] kd);
      if (top_idx >= DEPTH - 1) return 0;
      top_idx++;
      sym_key[top_idx] = k;
      sym_kind[top_idx] = kd;
      sym_level[top_idx] = nest[2:0];
      sym_addr[top_idx] = 0;
      sym_value[top_idx] = 0;
      sym_pcount[top_idx] = 0;
      if (top_idx > high_water) high_water = top_idx;
      return top_idx;
   endfunction

   function automatic lookup_type symtab_step(cmd_type c);
      lookup_type r;
      int idx, pc;
      bit ovf;
      idx = 0;
      ovf = 0;
      case (c.action)
         sst_pkg::ACT_OPEN: begin
            if (nest >= LEVELS - 1) begin
               ovf = 1;
            end else if (nest < 0) begin
               top_idx = 0;
               local_addr = clip16(longint'(c.opv));
               nest = 0;
            end else begin
               saved_top[nest] = top_idx;
               saved_addr[nest] = local_addr;
               local_addr = clip16(longint'(c.opv));
               nest++;
            end
         end
         sst_pkg::ACT_CLOSE: begin
            if (nest > 0) begin
               nest--;
               top_idx = saved_top[nest];
               local_addr = saved_addr[nest];
            end else if (nest == 0) begin
               nest = -1;
            end
         end
         sst_pkg::ACT_FUNC: begin
            idx = claim_entry(c.key, sst_pkg::KIND_FUNC);
            if (idx != 0) begin
               sym_addr[idx] = clip16(longint'(c.opv));
               func_idx = idx;
            end
         end
         sst_pkg::ACT_PARAM: begin
            idx = claim_entry(c.key, sst_pkg::KIND_PARAM);
            if (idx != 0 && sym_pcount[func_idx] < sst_pkg::PCOUNT_MAX) begin
               sym_pcount[func_idx]++;
            end
         end
         sst_pkg::ACT_VAR: begin
            idx = claim_entry(c.key, sst_pkg::KIND_VAR);
            if (idx != 0) begin
               sym_addr[idx] = local_addr;
               if (local_addr < sst_pkg::ADDR_MAX) local_addr++;
            end
         end
         sst_pkg::ACT_CONST: begin
            idx = claim_entry(c.key, sst_pkg::KIND_CONST);
            if (idx != 0) sym_value[idx] = c.opv;
         end
         sst_pkg::ACT_ENDP: begin
            idx = func_idx;
            pc = sym_pcount[idx];
            for (int i = 1; i <= pc; i++) begin
               if (idx + i < DEPTH) sym_addr[idx + i] = i - 1 - pc;
            end
         end
         sst_pkg::ACT_CHANGE: begin
            idx = int'(c.target);
            sym_addr[idx] = clip16(longint'(c.opv));
         end
         sst_pkg::ACT_SEARCH: begin
            for (int i = top_idx; i >= 1; i--) begin
               if (idx == 0 && sym_key[i] == c.key) idx = i;
            end
         end
         sst_pkg::ACT_READ: idx = int'(c.target);
         default: ;
      endcase
      if (ovf) idx = 0;
      if (c.action >= sst_pkg::ACT_FUNC && c.action <= sst_pkg::ACT_CONST && idx == 0) ovf = 1;
      r.index = idx[6:0];
      if (idx != 0) begin
         r.kind = sym_kind[idx];
         r.level = sym_level[idx];
         r.address = sym_addr[idx][15:0];
         r.value = sym_value[idx];
      end else begin
         r.kind = '0;
         r.level = '0;
         r.address = '0;
         r.value = '0;
      end
      r.cur_level = nest[3:0];
      r.next_addr = local_addr[15:0];
      pc = 0;
      if (nest > 0) pc = sym_pcount[saved_top[nest - 1]];
      r.pcount = pc[6:0];
      r.ovf = ovf;
      return r;
   endfunction

   function automatic logic signed [31:0] pick_opv();
      case ($urandom_range(0, 5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $urandom();
         3: return $signed($urandom_range(0, 80000)) - 40000;
         default: return $urandom_range(0, 40);
      endcase
   endfunction

   function automatic logic [63:0] pick_key();
      if ($urandom_range(0, 9) < 7) return key_pool[$urandom_range(0, 15)];
      return {$urandom(), $urandom()};
   endfunction

   // Keep every command away from entries that were never written.
   task automatic queue_cmd(logic [3:0] a, logic [63:0] k, logic signed [31:0] v,
                            logic [6:0] t);
      cmd_type c;
      if (a == sst_pkg::ACT_OPEN && nest >= 0 && nest < LEVELS - 1 && top_idx == 0) begin
         a = sst_pkg::ACT_FUNC;
      end
      if ((a == sst_pkg::ACT_PARAM || a == sst_pkg::ACT_ENDP) && func_idx == 0) begin
         a = sst_pkg::ACT_FUNC;
      end
      if ((a == sst_pkg::ACT_CHANGE || a == sst_pkg::ACT_READ) && t > high_water) begin
         t = 7'(high_water);
      end
      c.action = a;
      c.key = k;
      c.opv = v;
      c.target = t;
      pending_cmds.push_back(c);
      pending_lookups.push_back(symtab_step(c));
   endtask

   task automatic random_cmd();
      int w;
      logic [3:0] a;
      w = $urandom_range(0, 99);
      if (w < 10) a = sst_pkg::ACT_OPEN;
      else if (w < 19) a = sst_pkg::ACT_CLOSE;
      else if (w < 26) a = sst_pkg::ACT_FUNC;
      else if (w < 34) a = sst_pkg::ACT_PARAM;
      else if (w < 48) a = sst_pkg::ACT_VAR;
      else if (w < 54) a = sst_pkg::ACT_CONST;
      else if (w < 59) a = sst_pkg::ACT_ENDP;
      else if (w < 64) a = sst_pkg::ACT_CHANGE;
      else if (w < 86) a = sst_pkg::ACT_SEARCH;
      else if (w < 96) a = sst_pkg::ACT_READ;
      else a = 4'($urandom_range(10, 15));
      queue_cmd(a, pick_key(), pick_opv(), 7'($urandom_range(0, 127)));
   endtask

   initial begin
      int n;
      foreach (key_pool[i]) key_pool[i] = {$urandom(), $urandom()};
      key_pool[0] = '0;
      key_pool[1] = '1;
      // directed opening
      queue_cmd(sst_pkg::ACT_VAR, key_pool[2], 32'sd0, 7'd0);    // entry before any block
      queue_cmd(sst_pkg::ACT_OPEN, 64'd0, 32'sd5, 7'd0);
      queue_cmd(sst_pkg::ACT_FUNC, key_pool[1], 32'sh7fffffff, 7'd0);
      queue_cmd(sst_pkg::ACT_PARAM, key_pool[0], 32'sd0, 7'd0);
      queue_cmd(sst_pkg::ACT_PARAM, key_pool[3], 32'sd0, 7'd0);
      queue_cmd(sst_pkg::ACT_ENDP, 64'd0, 32'sd0, 7'd0);
      queue_cmd(sst_pkg::ACT_VAR, key_pool[4], 32'sd0, 7'd0);
      queue_cmd(sst_pkg::ACT_CONST, key_pool[5], 32'sh80000000, 7'd0);
      queue_cmd(sst_pkg::ACT_OPEN, 64'd0, 32'sh7fffffff, 7'd0);
      queue_cmd(sst_pkg::ACT_VAR, key_pool[6], 32'sd0, 7'd0);
      queue_cmd(sst_pkg::ACT_VAR, key_pool[7], 32'sd0, 7'd0);    // local address pinned at max
      queue_cmd(sst_pkg::ACT_SEARCH, key_pool[1], 32'sd0, 7'd0);
      queue_cmd(sst_pkg::ACT_SEARCH, key_pool[15] ^ 64'h1, 32'sd0, 7'd0);
      queue_cmd(sst_pkg::ACT_CHANGE, 64'd0, -32'sd40000, 7'd1);
      queue_cmd(sst_pkg::ACT_CHANGE, 64'd0, 32'sh7fffffff, 7'h7f);
      queue_cmd(sst_pkg::ACT_READ, 64'd0, 32'sd0, 7'd1);
      queue_cmd(sst_pkg::ACT_READ, 64'd0, 32'sd0, 7'd0);
      queue_cmd(4'hf, '1, '1, '1);
      for (int i = 0; i < 7; i++) begin
         queue_cmd(sst_pkg::ACT_OPEN, 64'd0, 32'sh80000000, 7'd0); // nesting full
      end
      n = 0;
      while (n < N_RANDOM) begin
         // fill the table now and then
         if ($urandom_range(0, 399) == 0) begin
            for (int i = 0; i < 130; i++) queue_cmd(sst_pkg::ACT_VAR, pick_key(), 32'sd0, 7'd0);
            n += 130;
         end else begin
            random_cmd();
            n++;
         end
      end
      for (int i = 0; i < 9; i++) queue_cmd(sst_pkg::ACT_CLOSE, 64'd0, 32'sd0, 7'd0);
      queue_cmd(sst_pkg::ACT_CLOSE, 64'd0, 32'sd0, 7'd0);        // ignored at level -1
      stim_done = 1;
   end

   int gap = 0;
   int burst = 0;
   bit busy_seen = 1'b0;

   // hold busy as it stood before the next rising edge
   always @(negedge clock) begin
      busy_seen = busy;
   end

   always @(posedge clock) begin
      bit take;
      logic next_start;
      cmd_type c;
      if (reset) begin
         start <= 1'b0;
      end else begin
         take = !(start && busy_seen);
         next_start = start;
         if (start && !busy_seen) expected_words.push_back(pending_lookups.pop_front());
         if (take) begin
            next_start = 1'b0;
            if (gap > 0) begin
               // count idle cycles only while the block is free
               if (!busy_seen) gap--;
            end else if (pending_cmds.size() > 0) begin
               c = pending_cmds.pop_front();
               req_action <= c.action;
               req_name_key <= c.key;
               req_operand_value <= c.opv;
               req_target_index <= c.target;
               next_start = 1'b1;
               // stretches with no idling, otherwise mostly short gaps
               if (burst > 0) begin
                  burst--;
               end else if ($urandom_range(0, 49) == 0) begin
                  burst = $urandom_range(10, 40);
               end else if ($urandom_range(0, 19) == 0) begin
                  gap = $urandom_range(20, 300);
               end else begin
                  gap = $urandom_range(0, 4);
               end
            end
         end
         start <= next_start;
      end
   end

   task automatic check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         failed = 1;
      end
   endtask

   // sample the result word mid-cycle, while it is stable
   always @(negedge clock) begin
      lookup_type e;
      if (!reset && rsp_strobe) begin
         if (expected_words.size() == 0) begin
            $error("unexpected result word");
            failed = 1;
         end else begin
            e = expected_words.pop_front();
            check_field("entry_index", longint'(e.index), longint'(rsp_entry_index));
            check_field("entry_kind", longint'(e.kind), longint'(rsp_entry_kind));
            check_field("entry_level", longint'(e.level), longint'(rsp_entry_level));
            check_field("entry_address", longint'(e.address), longint'(rsp_entry_address));
            check_field("entry_value", longint'(e.value), longint'(rsp_entry_value));
            check_field("current_level", longint'(e.cur_level), longint'(rsp_current_level));
            check_field("next_local_address", longint'(e.next_addr),
                        longint'(rsp_next_local_address));
            check_field("param_count", longint'(e.pcount), longint'(rsp_param_count));
            check_field("overflow", longint'(e.ovf), longint'(rsp_overflow));
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done);
      while (pending_cmds.size() > 0 || pending_lookups.size() > 0 ||
             expected_words.size() > 0 || start) @(posedge clock);
      repeat (600) @(posedge clock);
      if (expected_words.size() > 0) begin
         $error("result words still outstanding");
         failed = 1;
      end
      if (!failed) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("status: fail");
      $finish;
   end
endmodule
